// ===== hw/rtl/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and constants for the frame deframer
// Item structs, phase encoding, opcodes and status codes.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int LENGTH_BITS_DEFAULT = 64;

  // Item entering the block: one received frame byte.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } rx_item_t;

  // Item leaving the block.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        done_res;
    logic [2:0]  status;
    logic [63:0] frame_length;
  } res_item_t;

  // Parser phase, one-hot.
  typedef enum logic [6:0] {
    PH_HDR0  = 7'b000_0001,
    PH_HDR1  = 7'b000_0010,
    PH_EXT   = 7'b000_0100,
    PH_KEY   = 7'b000_1000,
    PH_PAY   = 7'b001_0000,
    PH_TRAIL = 7'b010_0000,
    PH_SKIP  = 7'b100_0000
  } phase_t;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_CLOSE        = 3'd1;
  localparam logic [2:0] ST_BAD_OPCODE   = 3'd2;
  localparam logic [2:0] ST_TRUNCATED    = 3'd3;
  localparam logic [2:0] ST_LEN_MISMATCH = 3'd4;
  localparam logic [2:0] ST_NO_MASK      = 3'd5;

endpackage

// ===== hw/rtl/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer: receive-side frame parser and payload unmasker
// Parses header, length and masking key of one buffer per frame and emits
// the unmasked payload bytes, then a done item with length and status.
// ----------------------------------------------------------------------------
// Result items are registered: an accepted byte item's result goes to the output register.
// Throughput: one byte item per cycle while downstream does not stall; the single output register is
//   refilled in the same cycle that its item is taken.
// Reset: rst (synchronous) returns the parser to the first header byte and
//   empties the output register. The last byte of a buffer does the same
//   to the parser state.
module websocket_frame_deframer #(
  parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  wsd_pkg::rx_item_t  byte_item,
  output logic               res_valid,
  input  logic               res_stall,
  output wsd_pkg::res_item_t res_item
);
  import wsd_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  // Parser state.
  phase_t                 phase,           phase_next;
  logic [3:0]             header_index,    header_index_next;
  logic [3:0]             opcode_seen,     opcode_seen_next;
  logic                   mask_flag,       mask_flag_next;
  logic [LENGTH_BITS-1:0] declared_length, declared_length_next;
  logic [LENGTH_BITS-1:0] payload_count,   payload_count_next;
  logic [31:0]            key_bytes,       key_bytes_next;
  logic [1:0]             bytes_seen,      bytes_seen_next;

  logic                   byte_fire;
  logic                   emit;
  logic                   last;
  logic [7:0]             b;
  logic [7:0]             key_sel;
  logic [LENGTH_BITS-1:0] count_inc;
  logic [6:0]             len7;
  logic [2:0]             status_calc;
  res_item_t              result;

  // The output register parts the two sides: hold input only while a
  // finished item sits there and downstream stalls.
  assign byte_stall = res_valid & res_stall;
  assign byte_fire  = byte_valid & ~byte_stall;

  assign b    = byte_item.in_byte;
  assign last = byte_item.last_byte;
  assign len7 = b[6:0];

  // Key byte for the current payload index, first key byte first.
  always_comb begin
    case (payload_count[1:0])
      2'd0:    key_sel = key_bytes[31:24];
      2'd1:    key_sel = key_bytes[23:16];
      2'd2:    key_sel = key_bytes[15:8];
      default: key_sel = key_bytes[7:0];
    endcase
  end

  // Saturating payload counter increment.
  assign count_inc = (payload_count == LEN_MAX) ? payload_count
                                                : payload_count + LENGTH_BITS'(1);

  // Next state for one byte.
  always_comb begin
    phase_next           = phase;
    header_index_next    = header_index;
    opcode_seen_next     = opcode_seen;
    mask_flag_next       = mask_flag;
    declared_length_next = declared_length;
    payload_count_next   = payload_count;
    key_bytes_next       = key_bytes;
    bytes_seen_next      = bytes_seen;
    emit                 = 1'b0;

    unique case (phase) inside
      PH_HDR0: begin
        // Low nibble is the opcode; only text and binary frames carry on.
        opcode_seen_next = b[3:0];
        if (b[3:0] == OP_TEXT || b[3:0] == OP_BINARY) begin
          phase_next = PH_HDR1;
        end else begin
          phase_next = PH_SKIP;
        end
      end
      PH_HDR1: begin
        mask_flag_next       = b[7];
        declared_length_next = '0;
        if (len7 == LEN_EXT16) begin
          header_index_next = EXT16_BYTES;
          phase_next        = PH_EXT;
        end else if (len7 == LEN_EXT64) begin
          header_index_next = EXT64_BYTES;
          phase_next        = PH_EXT;
        end else begin
          declared_length_next = LENGTH_BITS'(len7);
          bytes_seen_next      = '0;
          phase_next           = PH_KEY;
        end
      end
      PH_EXT: begin
        // Shift in big-endian length bytes; saturate if the length overflows.
        if (declared_length[LENGTH_BITS-1 -: 8] != 8'd0) begin
          declared_length_next = LEN_MAX;
        end else begin
          declared_length_next = {declared_length[LENGTH_BITS-9:0], b};
        end
        header_index_next = header_index - 4'd1;
        if (header_index == 4'd1) begin
          bytes_seen_next = '0;
          phase_next      = PH_KEY;
        end
      end
      PH_KEY: begin
        key_bytes_next  = {key_bytes[23:0], b};
        bytes_seen_next = bytes_seen + 2'd1;
        if (bytes_seen == 2'd3) begin
          payload_count_next = '0;
          phase_next = (declared_length == '0) ? PH_TRAIL : PH_PAY;
        end
      end
      PH_PAY: begin
        emit               = 1'b1;
        payload_count_next = count_inc;
        if (count_inc >= declared_length) begin
          phase_next = PH_TRAIL;
        end
      end
      PH_TRAIL, PH_SKIP: begin
        // Drop bytes past the payload or of a rejected frame.
      end
      default: begin
        phase_next = PH_HDR0;
      end
    endcase
  end

  // Status for the buffer's last byte, in order of precedence.
  always_comb begin
    if (phase == PH_HDR0) begin
      status_calc = ST_TRUNCATED;
    end else if (opcode_seen_next == OP_CLOSE) begin
      status_calc = ST_CLOSE;
    end else if (opcode_seen_next != OP_TEXT && opcode_seen_next != OP_BINARY) begin
      status_calc = ST_BAD_OPCODE;
    end else if (phase_next == PH_EXT) begin
      status_calc = ST_TRUNCATED;
    end else if (phase_next == PH_KEY || phase_next == PH_PAY) begin
      status_calc = ST_LEN_MISMATCH;
    end else if (!mask_flag_next) begin
      status_calc = ST_NO_MASK;
    end else begin
      status_calc = ST_OK;
    end
  end

  // Assemble the result item.
  always_comb begin
    result.out_byte     = emit ? (b ^ key_sel) : 8'd0;
    result.out_valid    = emit;
    result.done_res     = last;
    result.status       = last ? status_calc : ST_OK;
    result.frame_length = '0;
    if (last && (phase_next == PH_KEY || phase_next == PH_PAY ||
                 phase_next == PH_TRAIL)) begin
      result.frame_length = 64'(declared_length_next);
    end
  end

  // Parser registers: advance on each accepted byte, clear at buffer end.
  always_ff @(posedge clk) begin
    if (rst || (byte_fire && last)) begin
      phase           <= PH_HDR0;
      header_index    <= '0;
      opcode_seen     <= '0;
      mask_flag       <= 1'b0;
      declared_length <= '0;
      payload_count   <= '0;
      key_bytes       <= '0;
      bytes_seen      <= '0;
    end else if (byte_fire) begin
      phase           <= phase_next;
      header_index    <= header_index_next;
      opcode_seen     <= opcode_seen_next;
      mask_flag       <= mask_flag_next;
      declared_length <= declared_length_next;
      payload_count   <= payload_count_next;
      key_bytes       <= key_bytes_next;
      bytes_seen      <= bytes_seen_next;
    end
  end

  // Output register: load a result when one is due, drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (byte_fire) begin
      res_valid <= emit | last;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_fire) begin
      res_item <= result;
    end
  end

endmodule

// ===== verif/tb_websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer: self-checking testbench for the frame deframer
// Feeds received buffers one byte item at a time, predicts every result item
// with an in-bench parser model and compares each field as results arrive.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer;
  import wsd_pkg::*;

  localparam int LENGTH_BITS = LENGTH_BITS_DEFAULT;
  localparam logic [63:0] LEN_MAX = {64{1'b1}} >> (64 - LENGTH_BITS);
  // Hold-off window for the backpressure test, in receiver cycles.
  localparam int HOLD_CYCLES = 80;
  // Upper bound on cycles spent waiting for due results to come out.
  localparam int DRAIN_LIMIT = 20000;

  typedef logic [7:0] byte_q_t[$];

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid;
  logic       byte_stall;
  rx_item_t   byte_item;
  logic       res_valid;
  logic       res_stall = 1'b0;
  res_item_t  res_item;

  // Idle rates in percent, changed between test phases.
  int send_idle_pct = 6;
  int recv_idle_pct = 55;
  // Receiver hold-off: request posted by a test, counted down by the stall process.
  int hold_request = 0;
  int hold_left = 0;

  int fail_count = 0;
  // Byte items accepted by the block so far.
  int sent_items = 0;

  // Results the parser model says are still to come, oldest first.
  res_item_t frame_results_due[$];

  // Parser model state.
  phase_t      m_phase;
  logic [3:0]  ext_left;
  logic [3:0]  opcode;
  logic        mask_bit;
  logic [63:0] decl_len;
  logic [63:0] pay_cnt;
  logic [31:0] mkey;
  logic [1:0]  key_cnt;

  always #4 clk = ~clk;

  websocket_frame_deframer dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item)
  );

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------

  // Return the model to the first header byte, as reset and every last byte do.
  task automatic reset_model();
    m_phase  = PH_HDR0;
    ext_left = '0;
    opcode   = '0;
    mask_bit = 1'b0;
    decl_len = '0;
    pay_cnt  = '0;
    mkey     = '0;
    key_cnt  = '0;
  endtask

  // Advance the parser model by one accepted byte item and queue the result
  // item it causes, if any.
  task automatic deframe_byte(input logic [7:0] b, input logic last);
    phase_t      was;
    res_item_t   r;
    logic [6:0]  len7;
    logic [31:0] key_sh;
    was = m_phase;
    r = '0;
    sent_items++;
    case (was)
      PH_HDR0: begin
        // Only text and binary frames are parsed; close and the rest are skipped.
        opcode = b[3:0];
        if (opcode == OP_TEXT || opcode == OP_BINARY)
          m_phase = PH_HDR1;
        else
          m_phase = PH_SKIP;
      end
      PH_HDR1: begin
        len7 = b[6:0];
        mask_bit = b[7];
        decl_len = '0;
        if (len7 == LEN_EXT16) begin
          ext_left = EXT16_BYTES;
          m_phase = PH_EXT;
        end else if (len7 == LEN_EXT64) begin
          ext_left = EXT64_BYTES;
          m_phase = PH_EXT;
        end else begin
          decl_len = 64'(len7);
          key_cnt = '0;
          m_phase = PH_KEY;
        end
      end
      PH_EXT: begin
        // Big-endian length; saturate if it no longer fits LENGTH_BITS.
        if ((decl_len >> (LENGTH_BITS - 8)) != 0)
          decl_len = LEN_MAX;
        else
          decl_len = ((decl_len << 8) | 64'(b)) & LEN_MAX;
        ext_left = ext_left - 4'd1;
        if (ext_left == 0) begin
          key_cnt = '0;
          m_phase = PH_KEY;
        end
      end
      PH_KEY: begin
        // First key byte ends up in bits 31..24.
        mkey = {mkey[23:0], b};
        key_cnt = key_cnt + 2'd1;
        if (key_cnt == 0) begin
          pay_cnt = '0;
          m_phase = (decl_len == 0) ? PH_TRAIL : PH_PAY;
        end
      end
      PH_PAY: begin
        key_sh = mkey >> (8 * (3 - int'(pay_cnt[1:0])));
        r.out_byte = b ^ key_sh[7:0];
        r.out_valid = 1'b1;
        if (pay_cnt < LEN_MAX)
          pay_cnt = pay_cnt + 64'd1;
        if (pay_cnt >= decl_len)
          m_phase = PH_TRAIL;
      end
      default: ;
    endcase

    if (r.out_valid || last) begin
      if (last) begin
        r.done_res = 1'b1;
        if (was == PH_HDR0)
          r.status = ST_TRUNCATED;
        else if (opcode == OP_CLOSE)
          r.status = ST_CLOSE;
        else if (opcode != OP_TEXT && opcode != OP_BINARY)
          r.status = ST_BAD_OPCODE;
        else if (m_phase == PH_EXT)
          r.status = ST_TRUNCATED;
        else if (m_phase == PH_KEY || m_phase == PH_PAY)
          r.status = ST_LEN_MISMATCH;
        else if (!mask_bit)
          r.status = ST_NO_MASK;
        else
          r.status = ST_OK;
        // Length is reported only once the length field is complete.
        if (m_phase == PH_KEY || m_phase == PH_PAY || m_phase == PH_TRAIL)
          r.frame_length = decl_len;
        reset_model();
      end
      frame_results_due.push_back(r);
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  // Compare every accepted result item with the oldest one due.
  always @(posedge clk) begin : check_results
    res_item_t want;
    if (!rst && res_valid && !res_stall) begin
      if (frame_results_due.size() == 0) begin
        report_error($sformatf("result item with nothing due: %h", res_item));
      end else begin
        want = frame_results_due.pop_front();
        if (res_item.out_byte !== want.out_byte)
          report_error($sformatf("out_byte got %h want %h",
                                 res_item.out_byte, want.out_byte));
        if (res_item.out_valid !== want.out_valid)
          report_error($sformatf("out_valid got %b want %b",
                                 res_item.out_valid, want.out_valid));
        if (res_item.done_res !== want.done_res)
          report_error($sformatf("done_res got %b want %b",
                                 res_item.done_res, want.done_res));
        if (res_item.status !== want.status)
          report_error($sformatf("status got %0d want %0d",
                                 res_item.status, want.status));
        if (res_item.frame_length !== want.frame_length)
          report_error($sformatf("frame_length got %h want %h",
                                 res_item.frame_length, want.frame_length));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver side: random stall, plus a counted hold-off on request
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left--;
    end else begin
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offer one byte item and wait for it to be taken. Called at a falling edge;
  // returns at a falling edge with valid still high, so the next call either
  // replaces the item or drops valid in that same step.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_item <= rx_item_t'{in_byte: b, last_byte: last};
    byte_valid <= 1'b1;
    @(posedge clk);
    while (byte_stall)
      @(posedge clk);
    deframe_byte(b, last);
    @(negedge clk);
  endtask

  // Send one received buffer; mark its final byte as last.
  task automatic send_buffer(input byte_q_t frame);
    foreach (frame[i])
      send_byte(frame[i], i == frame.size() - 1);
  endtask

  // Drop valid and hold the sender until every due result has come out.
  task automatic drain_results();
    int waited;
    waited = 0;
    byte_valid <= 1'b0;
    @(negedge clk);
    while (frame_results_due.size() != 0 && waited < DRAIN_LIMIT) begin
      waited++;
      @(negedge clk);
    end
    if (frame_results_due.size() != 0)
      report_error($sformatf("%0d result items never arrived", frame_results_due.size()));
  endtask

  // Build one buffer: mostly well-formed frames with random content, some
  // cut short, some with trailing bytes, and a share of plain noise.
  function automatic byte_q_t random_buffer();
    byte_q_t     f;
    int          kind;
    int          form;
    int          n_pay;
    int          cut;
    int          i;
    logic [63:0] len;
    logic [3:0]  op;
    logic        mask;
    kind = $urandom_range(99);
    if (kind >= 80) begin
      // Noise: any first byte (close, bad opcodes included), random tail.
      f.push_back(8'($urandom));
      repeat ($urandom_range(11))
        f.push_back(8'($urandom));
      return f;
    end
    op = $urandom_range(1) ? OP_TEXT : OP_BINARY;
    mask = ($urandom_range(9) != 0);
    form = $urandom_range(99);
    f.push_back({4'($urandom), op});
    if (form < 70) begin
      len = ($urandom_range(19) == 0) ? 64'($urandom_range(125))
                                      : 64'($urandom_range(20));
      f.push_back({mask, 7'(len)});
    end else if (form < 85) begin
      len = ($urandom_range(9) == 0) ? 64'($urandom_range(65535))
                                     : 64'($urandom_range(40));
      f.push_back({mask, LEN_EXT16});
      f.push_back(len[15:8]);
      f.push_back(len[7:0]);
    end else begin
      len = ($urandom_range(9) == 0) ? {$urandom, $urandom} : 64'($urandom_range(40));
      f.push_back({mask, LEN_EXT64});
      for (i = 7; i >= 0; i--)
        f.push_back(len[8*i +: 8]);
    end
    repeat (4)
      f.push_back(8'($urandom));
    // Huge declared lengths get a short payload and end as a mismatch.
    n_pay = (len > 200) ? $urandom_range(20) : int'(len);
    repeat (n_pay)
      f.push_back(8'($urandom));
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3))
        f.push_back(8'($urandom));
    if ($urandom_range(6) == 0) begin
      cut = $urandom_range(1, f.size());
      while (f.size() > cut)
        void'(f.pop_back());
    end
    return f;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // One frame per special case of the parser.
  task automatic test_directed();
    // Single-byte buffer: header truncated.
    send_buffer('{8'h81});
    // Masked text frame, one payload byte; key has all-ones and all-zeros bytes.
    send_buffer('{8'h81, 8'h81, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hFF});
    // Close frame: rest ignored.
    send_buffer('{8'h88, 8'h80});
    // Reserved opcode.
    send_buffer('{8'h03, 8'h7F});
    // 16-bit length cut after its first byte.
    send_buffer('{8'h02, 8'hFE, 8'h01});
    // Zero length, mask clear, one trailing byte to ignore.
    send_buffer('{8'h02, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'hEE});
    // Largest 16-bit length, buffer ends before the key.
    send_buffer('{8'h82, 8'hFE, 8'hFF, 8'hFF});
  endtask

  // Random buffers until n_items more byte items have been sent.
  task automatic test_random_frames(input int n_items);
    int stop_at;
    stop_at = sent_items + n_items;
    while (sent_items < stop_at)
      send_buffer(random_buffer());
  endtask

  // Hold the receiver off while a long frame streams in, so the block's
  // output fills and it stalls its input.
  task automatic test_backpressure();
    byte_q_t f;
    int      i;
    drain_results();
    // Binary, masked, 100-byte payload.
    f = '{8'h82, 8'hE4, 8'h3C, 8'hC3, 8'h96, 8'h69};
    for (i = 0; i < 100; i++)
      f.push_back(8'($urandom));
    @(posedge clk);
    hold_request = HOLD_CYCLES;
    @(negedge clk);
    send_buffer(f);
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    byte_valid = 1'b0;
    byte_item = '0;
    reset_model();
    // Hold reset, then release it at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    // Sender mostly busy, receiver stalls often.
    test_random_frames(320);
    // Swap: sender gaps often, receiver rarely stalls.
    send_idle_pct = 55;
    recv_idle_pct = 6;
    test_random_frames(320);
    // No random idling from here on.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_frames(320);

    drain_results();
    // Give a stray result item time to show up.
    repeat (4) @(negedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog: end a hung run.
  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/wsd_pkg.sv
hw/rtl/websocket_frame_deframer.sv
verif/tb_websocket_frame_deframer.sv
